### rtl/wavetable_oscillator_interp_unit_macros.svh
// Assertion helpers shared by the oscillator RTL.
`ifndef WAVETABLE_OSCILLATOR_INTERP_UNIT_MACROS_SVH
`define WAVETABLE_OSCILLATOR_INTERP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTOI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtoi: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WTOI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtoi: next-cycle check failed");

`endif

### rtl/wtoi_pkg.sv
`timescale 1ns / 1ps

package wtoi_pkg;

    // Fixed field widths of the command and configuration ports.
    localparam int CMD_BITS       = 2;
    localparam int SIZE_BITS      = 10;
    localparam int PINC_BITS      = 32;
    localparam int FS_BITS        = 16;
    localparam int FS_FRAC        = 8;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd512;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_INC   = 1'b1;

    // Command codes; the fourth code is a no-op.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE      = 2'd0,
        CMD_GEN        = 2'd1,
        CMD_GEN_SCALED = 2'd2
    } t_cmd;

    // Status of the modulo reduction unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_mr_stat;

endpackage

### rtl/wtoi_ifs.sv
`timescale 1ns / 1ps

// Command channel: table writes and generate requests.
interface wtoi_in_if #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [wtoi_pkg::CMD_BITS-1:0]        cmd;
    logic [ADDR_BITS-1:0]                 table_address;
    logic signed [SAMPLE_BITS-1:0]        table_value;
    logic signed [wtoi_pkg::FS_BITS-1:0]  freq_scale;

    modport source (output valid, cmd, table_address, table_value, freq_scale,
                    input ready);
    modport sink   (input valid, cmd, table_address, table_value, freq_scale,
                    output ready);
endinterface

// Sample channel: one interpolated sample per beat.
interface wtoi_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

### rtl/wtoi_mod_reduce.sv
`timescale 1ns / 1ps

// Bit-serial floor modulo: result = (neg ? -mag : mag) mod div, in [0, div).
// One restoring-division step per cycle, DW steps per run.
module wtoi_mod_reduce #(
    parameter int DW = 10,
    parameter int IW = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DW-1:0]      i_mag,
    input  logic               i_neg,
    input  logic [IW-1:0]      i_div,
    output wtoi_pkg::t_mr_stat o_stat,
    output logic [IW-1:0]      o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [IW-1:0] r_rem;
    logic          r_neg;

    logic [IW:0]   trial;
    logic [IW:0]   diff;
    logic [IW-1:0] n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[DW-1]};
        diff  = trial - {1'b0, i_div};
        if (trial >= {1'b0, i_div}) begin
            n_rem = diff[IW-1:0];
        end else begin
            n_rem = trial[IW-1:0];
        end
    end

    // Step counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_mag;
            r_rem <= '0;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    // A negative operand with a nonzero remainder folds up into [0, div).
    always_comb begin
        o_stat.busy = r_busy;
        o_stat.done = r_done;
        if (r_neg && (r_rem != '0)) begin
            o_rem = i_div - r_rem;
        end else begin
            o_rem = r_rem;
        end
    end

endmodule

### rtl/wavetable_oscillator_interp_unit.sv
`timescale 1ns / 1ps
`include "wavetable_oscillator_interp_unit_macros.svh"

// Channel     Role     Beat carries
// i_cmd_ch    sink     cmd, table_address, table_value, freq_scale
// o_smp_ch    source   sample (one per generate command)
// i_cfg_*     write    register index and data, no handshake
//
// One command per cycle while i_cmd_ch.ready is high; a sample passes stages 1 to 5 and leaves from stage 5.
// The phase loop is one add and wrap in the table-read stage.
// After any register write, commands are held off while the bit-serial modulo units
// re-reduce phase and step.
// Reset is synchronous, active low; the table contents are not cleared.
// A stalled sample waits in the output register while earlier stages keep filling.
module wavetable_oscillator_interp_unit #(
    parameter int TABLE_SIZE      = 512,
    parameter int PHASE_FRAC_BITS = 22,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wtoi_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [wtoi_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    wtoi_in_if.sink                             i_cmd_ch,
    wtoi_out_if.source                          o_smp_ch
);
    localparam int FB    = PHASE_FRAC_BITS;
    localparam int SB    = SAMPLE_BITS;
    localparam int IW    = $clog2(TABLE_SIZE + 1);
    localparam int PW    = IW + FB;
    localparam int DWP   = wtoi_pkg::PINC_BITS - FB;
    localparam int PRODW = wtoi_pkg::PINC_BITS + wtoi_pkg::FS_BITS;
    localparam int SCW   = PRODW - wtoi_pkg::FS_FRAC;
    localparam int SW    = (PW + 1 > SCW) ? PW + 1 : SCW;

    // Clamp the written cycle length to [2, TABLE_SIZE].
    function automatic logic [IW-1:0] f_eff_size(input logic [wtoi_pkg::SIZE_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w < 32'd2) begin
            return IW'(2);
        end else if (w > 32'(TABLE_SIZE)) begin
            return IW'(TABLE_SIZE);
        end
        return IW'(v);
    endfunction

    // Configuration and phase state.
    logic [IW-1:0]                        r_eff;
    logic signed [wtoi_pkg::PINC_BITS-1:0] r_pinc;
    logic                                 r_kick;
    logic [PW-1:0]                        r_phase;
    logic [PW-1:0]                        r_phase_src;
    logic [PW-1:0]                        r_pinc_red;

    // Pipeline stages.
    logic                    r_s1_v;
    wtoi_pkg::t_cmd          r_s1_cmd;
    logic [IW-1:0]           r_s1_addr;
    logic signed [SB-1:0]    r_s1_val;
    logic signed [wtoi_pkg::FS_BITS-1:0] r_s1_fs;

    logic                    r_s2_v;
    wtoi_pkg::t_cmd          r_s2_cmd;
    logic [IW-1:0]           r_s2_addr;
    logic signed [SB-1:0]    r_s2_val;
    logic signed [PRODW-1:0] r_s2_prod;

    logic                    r_s3_v;
    wtoi_pkg::t_cmd          r_s3_cmd;
    logic [IW-1:0]           r_s3_addr;
    logic signed [SB-1:0]    r_s3_val;
    logic [PW-1:0]           r_s3_step;

    logic                    r_s4_v;
    logic signed [SB-1:0]    r_s4_a;
    logic signed [SB-1:0]    r_s4_b;
    logic [FB-1:0]           r_s4_frac;

    logic                    r_s5_v;
    logic signed [SB-1:0]    r_s5_sample;

    logic signed [SB-1:0]    mem [0:TABLE_SIZE];

    // Handshake and control.
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic acc;
    logic red_busy;
    logic gen3;
    logic gen_fire;
    logic mem_we;

    wtoi_pkg::t_mr_stat ph_stat;
    wtoi_pkg::t_mr_stat pi_stat;
    logic [IW-1:0]      ph_rem;
    logic [IW-1:0]      pi_rem;
    logic               ph_apply;
    logic               pi_apply;

    logic [PW-1:0]      mod_w;
    logic signed [DWP-1:0] pinc_ip;
    logic [DWP-1:0]     pinc_mag;

    logic signed [PRODW-1:0] prod_c;
    logic signed [SCW-1:0]   scaled;
    logic signed [SW-1:0]    s_ext;
    logic signed [SW-1:0]    lim;
    logic signed [SW-1:0]    s_sat;
    logic signed [SW-1:0]    s_pos;
    logic [PW-1:0]           n_step;

    logic [PW:0]             ph_sum;
    logic [PW:0]             ph_wrap;
    logic [PW-1:0]           n_phase;
    logic [IW-1:0]           idx;
    logic [IW-1:0]           idx1;

    logic signed [SB:0]      d;
    logic [SB:0]             d_mag;
    logic [FB+SB:0]          i_prod;
    logic [SB:0]             q;
    logic signed [SB+1:0]    qs;
    logic signed [SB+1:0]    s_sum;

    // Stage readiness: a stage loads when empty or when it drains this cycle.
    always_comb begin
        rdy5     = !r_s5_v || o_smp_ch.ready;
        rdy4     = !r_s4_v || rdy5;
        rdy3     = !r_s3_v || rdy4;
        rdy2     = !r_s2_v || rdy3;
        rdy1     = !r_s1_v || rdy2;
        red_busy = r_kick || ph_stat.busy || ph_stat.done || pi_stat.busy || pi_stat.done;
        acc      = i_cmd_ch.valid && i_cmd_ch.ready;
    end

    assign i_cmd_ch.ready = rdy1 && !red_busy && !i_cfg_we;
    assign o_smp_ch.valid  = r_s5_v;
    assign o_smp_ch.sample = r_s5_sample;

    // Register writes; each one triggers a fresh reduction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff  <= f_eff_size(wtoi_pkg::SIZE_RESET);
            r_pinc <= '0;
            r_kick <= 1'b0;
        end else begin
            r_kick <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wtoi_pkg::CFG_ACTIVE_SIZE: begin
                        r_eff <= f_eff_size(i_cfg_data[wtoi_pkg::SIZE_BITS-1:0]);
                    end
                    wtoi_pkg::CFG_PHASE_INC: begin
                        r_pinc <= signed'(i_cfg_data[wtoi_pkg::PINC_BITS-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Operands of the two reductions.
    always_comb begin
        mod_w    = {r_eff, {FB{1'b0}}};
        pinc_ip  = r_pinc[wtoi_pkg::PINC_BITS-1:FB];
        pinc_mag = pinc_ip[DWP-1] ? DWP'(-pinc_ip) : DWP'(pinc_ip);
        ph_apply = ph_stat.done && !r_kick && !i_cfg_we;
        pi_apply = pi_stat.done && !r_kick && !i_cfg_we;
    end

    // Integer part of the stored phase, modulo the cycle length.
    wtoi_mod_reduce #(
        .DW (IW),
        .IW (IW)
    ) u_ph_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_mag   (r_phase_src[PW-1:FB]),
        .i_neg   (1'b0),
        .i_div   (r_eff),
        .o_stat  (ph_stat),
        .o_rem   (ph_rem)
    );

    // Integer part of the plain step, floor modulo the cycle length.
    wtoi_mod_reduce #(
        .DW (DWP),
        .IW (IW)
    ) u_pi_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_mag   (pinc_mag),
        .i_neg   (pinc_ip[DWP-1]),
        .i_div   (r_eff),
        .o_stat  (pi_stat),
        .o_rem   (pi_rem)
    );

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_v <= acc;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (rdy4) begin
                r_s4_v <= r_s3_v && gen3;
            end
            if (rdy5) begin
                r_s5_v <= r_s4_v;
            end
        end
    end

    // Stage 1: command capture.
    always_ff @(posedge i_clk) begin
        if (rdy1 && acc) begin
            r_s1_cmd  <= wtoi_pkg::t_cmd'(i_cmd_ch.cmd);
            r_s1_addr <= IW'(i_cmd_ch.table_address);
            r_s1_val  <= i_cmd_ch.table_value;
            r_s1_fs   <= i_cmd_ch.freq_scale;
        end
    end

    // Stage 2: scaled step product.
    assign prod_c = PRODW'(r_pinc) * PRODW'(r_s1_fs);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_cmd  <= r_s1_cmd;
            r_s2_addr <= r_s1_addr;
            r_s2_val  <= r_s1_val;
            r_s2_prod <= prod_c;
        end
    end

    // Stage 3: step in [0, mod): scaled steps get floor shift, saturation, fold of negatives.
    always_comb begin
        scaled = r_s2_prod[PRODW-1:wtoi_pkg::FS_FRAC];
        s_ext  = SW'(scaled);
        lim    = signed'(SW'(mod_w)) - SW'(1);
        if (s_ext > lim) begin
            s_sat = lim;
        end else if (s_ext < -lim) begin
            s_sat = -lim;
        end else begin
            s_sat = s_ext;
        end
        if (s_sat < 0) begin
            s_pos = s_sat + signed'(SW'(mod_w));
        end else begin
            s_pos = s_sat;
        end
        if (r_s2_cmd == wtoi_pkg::CMD_GEN_SCALED) begin
            n_step = s_pos[PW-1:0];
        end else begin
            n_step = r_pinc_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_cmd  <= r_s2_cmd;
            r_s3_addr <= r_s2_addr;
            r_s3_val  <= r_s2_val;
            r_s3_step <= n_step;
        end
    end

    // Stage 4: table access and phase advance.
    always_comb begin
        gen3     = (r_s3_cmd == wtoi_pkg::CMD_GEN) || (r_s3_cmd == wtoi_pkg::CMD_GEN_SCALED);
        gen_fire = rdy4 && r_s3_v && gen3;
        mem_we   = rdy4 && r_s3_v && (r_s3_cmd == wtoi_pkg::CMD_WRITE)
                   && (32'(r_s3_addr) <= 32'(TABLE_SIZE));
        idx      = r_phase[PW-1:FB];
        idx1     = idx + 1'b1;
        ph_sum   = {1'b0, r_phase} + {1'b0, r_s3_step};
        ph_wrap  = ph_sum - {1'b0, mod_w};
        if (ph_sum >= {1'b0, mod_w}) begin
            n_phase = ph_wrap[PW-1:0];
        end else begin
            n_phase = ph_sum[PW-1:0];
        end
    end

    // Phase registers: the working copy, the value last left by a sample, and the reduced plain step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_phase_src <= '0;
            r_pinc_red  <= '0;
        end else begin
            if (gen_fire) begin
                r_phase     <= n_phase;
                r_phase_src <= n_phase;
            end else if (ph_apply) begin
                r_phase <= {ph_rem, r_phase_src[FB-1:0]};
            end
            if (pi_apply) begin
                r_pinc_red <= {pi_rem, r_pinc[FB-1:0]};
            end
        end
    end

    // Wavetable with one write and two registered reads.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_s3_addr] <= r_s3_val;
        end
        if (gen_fire) begin
            r_s4_a <= mem[idx];
            r_s4_b <= mem[idx1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_s4_frac <= r_phase[FB-1:0];
        end
    end

    // Stage 5: a + frac * (b - a), with the product truncated toward zero.
    always_comb begin
        d      = signed'({r_s4_b[SB-1], r_s4_b}) - signed'({r_s4_a[SB-1], r_s4_a});
        d_mag  = d[SB] ? (SB+1)'(-d) : (SB+1)'(d);
        i_prod = {{(SB+1){1'b0}}, r_s4_frac} * {{FB{1'b0}}, d_mag};
        q      = i_prod[FB+SB:FB];
        qs     = d[SB] ? -signed'({1'b0, q}) : signed'({1'b0, q});
        s_sum  = signed'({{2{r_s4_a[SB-1]}}, r_s4_a}) + qs;
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_s4_v) begin
            r_s5_sample <= s_sum[SB-1:0];
        end
    end

    // Phase and plain step stay inside the cycle whenever commands may enter.
    `WTOI_ASSERT_IMP(a_phase_in_range, i_clk, i_rst_n, !red_busy, (r_phase < mod_w) && (r_pinc_red < mod_w))
    // Every step that reaches the phase adder is already reduced.
    `WTOI_ASSERT_IMP(a_step_in_range, i_clk, i_rst_n, r_s3_v && gen3, r_s3_step < mod_w)
    // A register write keeps the command channel closed in the following cycle.
    `WTOI_ASSERT_NXT(a_cfg_blocks_cmd, i_clk, i_rst_n, i_cfg_we, !acc)
    // Interpolation work only starts from a generate command.
    `WTOI_ASSERT_IMP(a_s4_from_gen, i_clk, i_rst_n, $rose(r_s4_v), $past(r_s3_v && gen3))

endmodule
